FILE: src/kwhm_pkg.sv
package kwhm_pkg;

  localparam int KEY_W = 32;
  localparam int RUN_W = 4;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_LAST  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  out_key;
    logic [RUN_W-1:0]  out_run;
    logic              done_res;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;
    logic start;
    logic take_next;
    logic take_last;
    logic drop;
    logic build_rd;
    logic fetch;
    logic child_rd;
    logic sift_move;
    logic sift_put;
    logic dec_build;
    logic top_rd;
    logic emit_top;
    logic emit_done;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic load_full;
    logic load_zero;
    logic load_lt2;
    logic active_zero;
    logic active_one;
    logic build_last;
    logic leaf;
    logic child_wins;
    logic out_free;
  } sts_t;

endpackage

FILE: src/kwhm_dpath.sv
module kwhm_dpath #(
  parameter int MAX_RUNS = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kwhm_pkg::in_item_t  in_data,
  input  kwhm_pkg::cmd_t      cmd,
  output kwhm_pkg::sts_t      sts,
  input  logic                out_ready,
  output logic                out_valid,
  output kwhm_pkg::out_item_t out_data
);
  import kwhm_pkg::*;

  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW    = $clog2(MAX_RUNS + 1);
  localparam int RW    = $clog2(MAX_RUNS);
  localparam int DEPTH = MAX_RUNS + 1;
  localparam logic [AW-1:0] CAP  = AW'(MAX_RUNS);
  localparam logic [AW-1:0] ROOT = AW'(1);

  logic [KW-1:0] keys_mem [DEPTH];
  logic [RW-1:0] runs_mem [DEPTH];

  logic [AW-1:0] active_r, active_nxt;
  logic [AW-1:0] load_r, load_nxt;
  logic [AW-1:0] build_r, build_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] child_r, child_nxt;
  logic          rv_r, rv_nxt;
  logic [KW-1:0] cur_key_r, cur_key_nxt;
  logic [RW-1:0] cur_run_r, cur_run_nxt;
  logic [RW-1:0] top_run_r, top_run_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic [KW-1:0] rd_a_key_r, rd_b_key_r;
  logic [RW-1:0] rd_a_run_r, rd_b_run_r;

  logic [AW:0]   left_w, right_w;
  logic          leaf, right_ok;
  logic [AW-1:0] right_addr, best_addr;
  logic          left_lt, right_lt;
  logic [KW-1:0] best_key, bk_left;
  logic [RW-1:0] best_run;

  logic          wr_en, rd_a_en, rd_b_en;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  logic [KW-1:0] wr_key;
  logic [RW-1:0] wr_run;

  logic [KW+KEY_W-1:0] key_ext;
  logic [RW+RUN_W-1:0] run_ext;

  assign left_w   = {slot_r, 1'b0};
  assign right_w  = left_w + (AW+1)'(1);
  assign leaf     = left_w > {1'b0, active_r};
  assign right_ok = right_w <= {1'b0, active_r};

  // pick the smaller child if it beats the held element; ties stay put
  assign right_addr = child_r + ROOT;
  assign left_lt    = rd_a_key_r < cur_key_r;
  assign bk_left    = left_lt ? rd_a_key_r : cur_key_r;
  assign right_lt   = rv_r && (rd_b_key_r < bk_left);
  assign best_addr  = right_lt ? right_addr : child_r;
  assign best_key   = right_lt ? rd_b_key_r : rd_a_key_r;
  assign best_run   = right_lt ? rd_b_run_r : rd_a_run_r;

  assign wr_en   = cmd.load_wr | cmd.sift_move | cmd.sift_put;
  assign rd_a_en = cmd.take_last | cmd.build_rd | cmd.child_rd | cmd.top_rd;
  assign rd_b_en = cmd.child_rd;

  always_comb begin
    wr_addr = slot_r;
    wr_key  = cur_key_r;
    wr_run  = cur_run_r;
    if (cmd.load_wr) begin
      wr_addr = load_r + ROOT;
      wr_key  = in_data.key[KW-1:0];
      wr_run  = RW'(load_r);
    end else if (cmd.sift_move) begin
      wr_key = best_key;
      wr_run = best_run;
    end
  end

  always_comb begin
    rd_a_addr = ROOT;
    if (cmd.take_last) begin
      rd_a_addr = active_r;
    end else if (cmd.build_rd) begin
      rd_a_addr = build_r;
    end else if (cmd.child_rd) begin
      rd_a_addr = left_w[AW-1:0];
    end
  end

  assign rd_b_addr = right_ok ? right_w[AW-1:0] : left_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[wr_addr] <= wr_key;
      runs_mem[wr_addr] <= wr_run;
    end
    if (rd_a_en) begin
      rd_a_key_r <= keys_mem[rd_a_addr];
      rd_a_run_r <= runs_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_key_r <= keys_mem[rd_b_addr];
      rd_b_run_r <= runs_mem[rd_b_addr];
    end
  end

  assign key_ext = {{KEY_W{1'b0}}, rd_a_key_r};
  assign run_ext = {{RUN_W{1'b0}}, rd_a_run_r};

  always_comb begin
    active_nxt    = active_r;
    load_nxt      = load_r;
    build_nxt     = build_r;
    slot_nxt      = slot_r;
    child_nxt     = child_r;
    rv_nxt        = rv_r;
    cur_key_nxt   = cur_key_r;
    cur_run_nxt   = cur_run_r;
    top_run_nxt   = top_run_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.load_wr) begin
      load_nxt = load_r + ROOT;
    end
    if (cmd.start) begin
      active_nxt = load_r;
      load_nxt   = '0;
      build_nxt  = load_r >> 1;
    end
    if (cmd.drop) begin
      active_nxt = '0;
    end
    if (cmd.take_last) begin
      active_nxt = active_r - ROOT;
      slot_nxt   = ROOT;
    end
    if (cmd.take_next) begin
      slot_nxt    = ROOT;
      cur_key_nxt = in_data.key[KW-1:0];
      cur_run_nxt = top_run_r;
    end
    if (cmd.build_rd) begin
      slot_nxt = build_r;
    end
    if (cmd.dec_build) begin
      build_nxt = build_r - ROOT;
    end
    if (cmd.fetch) begin
      cur_key_nxt = rd_a_key_r;
      cur_run_nxt = rd_a_run_r;
    end
    if (cmd.child_rd) begin
      child_nxt = left_w[AW-1:0];
      rv_nxt    = right_ok;
    end
    if (cmd.sift_move) begin
      slot_nxt = best_addr;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_top) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_key  = key_ext[KEY_W-1:0];
      out_data_nxt.out_run  = run_ext[RUN_W-1:0];
      out_data_nxt.done_res = 1'b0;
      top_run_nxt           = rd_a_run_r;
    end else if (cmd.emit_done) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_key  = '0;
      out_data_nxt.out_run  = '0;
      out_data_nxt.done_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      load_r      <= '0;
      build_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      load_r      <= load_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    child_r    <= child_nxt;
    rv_r       <= rv_nxt;
    cur_key_r  <= cur_key_nxt;
    cur_run_r  <= cur_run_nxt;
    top_run_r  <= top_run_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.load_full   = load_r == CAP;
  assign sts.load_zero   = load_r == '0;
  assign sts.load_lt2    = load_r[AW-1:1] == '0;
  assign sts.active_zero = active_r == '0;
  assign sts.active_one  = active_r == ROOT;
  assign sts.build_last  = build_r == ROOT;
  assign sts.leaf        = leaf;
  assign sts.child_wins  = left_lt | right_lt;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/kwhm_ctrl.sv
module kwhm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kwhm_pkg::mode_t in_mode,
  input  kwhm_pkg::sts_t  sts,
  output kwhm_pkg::cmd_t  cmd
);
  import kwhm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_BUILD_RD  = 8'b0000_0010,
    ST_FETCH     = 8'b0000_0100,
    ST_SIFT_RD   = 8'b0000_1000,
    ST_SIFT_CMP  = 8'b0001_0000,
    ST_TOP_RD    = 8'b0010_0000,
    ST_EMIT_TOP  = 8'b0100_0000,
    ST_EMIT_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   building_r, building_nxt;

  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    state_nxt    = state_r;
    building_nxt = building_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD: begin
              cmd.load_wr = sts.active_zero && !sts.load_full;
            end
            MODE_START: begin
              cmd.start = 1'b1;
              if (sts.load_zero) begin
                state_nxt = ST_EMIT_DONE;
              end else if (sts.load_lt2) begin
                state_nxt = ST_TOP_RD;
              end else begin
                building_nxt = 1'b1;
                state_nxt    = ST_BUILD_RD;
              end
            end
            MODE_NEXT: begin
              if (sts.active_zero) begin
                state_nxt = ST_EMIT_DONE;
              end else begin
                cmd.take_next = 1'b1;
                state_nxt     = ST_SIFT_RD;
              end
            end
            MODE_LAST: begin
              if (sts.active_zero) begin
                state_nxt = ST_EMIT_DONE;
              end else if (sts.active_one) begin
                cmd.drop  = 1'b1;
                state_nxt = ST_EMIT_DONE;
              end else begin
                cmd.take_last = 1'b1;
                state_nxt     = ST_FETCH;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BUILD_RD: begin
        cmd.build_rd = 1'b1;
        state_nxt    = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SIFT_RD;
      end
      ST_SIFT_RD, ST_SIFT_CMP: begin
        if (state_r == ST_SIFT_RD && !sts.leaf) begin
          cmd.child_rd = 1'b1;
          state_nxt    = ST_SIFT_CMP;
        end else if (state_r == ST_SIFT_CMP && sts.child_wins) begin
          cmd.sift_move = 1'b1;
          state_nxt     = ST_SIFT_RD;
        end else begin
          // settle the held element, then move to the next build slot or the top
          cmd.sift_put = 1'b1;
          if (building_r && !sts.build_last) begin
            cmd.dec_build = 1'b1;
            state_nxt     = ST_BUILD_RD;
          end else begin
            building_nxt = 1'b0;
            state_nxt    = ST_TOP_RD;
          end
        end
      end
      ST_TOP_RD: begin
        cmd.top_rd = 1'b1;
        state_nxt  = ST_EMIT_TOP;
      end
      ST_EMIT_TOP: begin
        if (sts.out_free) begin
          cmd.emit_top = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        building_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      building_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      building_r <= building_nxt;
    end
  end

endmodule

FILE: src/k_way_heap_merger_top.sv
// K-way merger over a binary min-heap of (key, run) pairs held in a small
// memory with one write and two registered read ports. A load request gives
// no result. The other requests walk the heap one level at a time (read both
// children, then compare and write one slot); a start request pays one such
// sift for each of the count/2 inner slots before the top is read. A new
// request is taken while the last result still waits on the output register.
module k_way_heap_merger_top #(
  parameter int MAX_RUNS = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kwhm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kwhm_pkg::out_item_t out_data
);
  import kwhm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kwhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwhm_dpath #(
    .MAX_RUNS (MAX_RUNS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // loads only append while no merge is running
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> sts.active_zero)
    else $error("heap append during merge");

  // a start request always moves the block out of idle, so input is held off
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == MODE_START) |=> !in_ready)
    else $error("start request did not hold off input");

  // children are read only below an inner slot
  a_child_inner: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.child_rd |-> !sts.leaf)
    else $error("child read past heap end");
`endif

endmodule

FILE: tb/sv/k_way_heap_merger_top_tb.sv
module k_way_heap_merger_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kwhm_pkg::*;

  localparam int RUNS = 16;
  localparam int RANDOM_ITEMS = 1700;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // predicted heap, slots numbered from 1
  logic [KEY_W-1:0] heap_key [1:RUNS];
  logic [RUN_W-1:0] heap_run [1:RUNS];
  int               merge_cnt;
  int               batch_cnt;
  out_item_t        merge_results [$];

  int  err_cnt;
  int  n_requests;
  int  n_results;
  int  n_done;
  int  n_merges;
  bit  no_gaps;

  k_way_heap_merger_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic void sift_heap(int slot);
    int               best;
    int               lc;
    int               rc;
    logic [KEY_W-1:0] tk;
    logic [RUN_W-1:0] tr;
    while (slot >= 1 && slot <= merge_cnt) begin
      best = slot;
      lc = 2 * slot;
      rc = lc + 1;
      if (lc <= merge_cnt && heap_key[lc] < heap_key[best]) best = lc;
      if (rc <= merge_cnt && heap_key[rc] < heap_key[best]) best = rc;
      if (best == slot) break;
      tk = heap_key[best];
      tr = heap_run[best];
      heap_key[best] = heap_key[slot];
      heap_run[best] = heap_run[slot];
      heap_key[slot] = tk;
      heap_run[slot] = tr;
      slot = best;
    end
  endfunction

  function automatic void queue_top();
    out_item_t e;
    if (merge_cnt == 0) begin
      e = '{out_key: '0, out_run: '0, done_res: 1'b1};
    end else begin
      e = '{out_key: heap_key[1], out_run: heap_run[1], done_res: 1'b0};
    end
    merge_results.push_back(e);
  endfunction

  function automatic void merge_request(mode_t m, logic [KEY_W-1:0] k);
    int i;
    case (m)
      MODE_LOAD: begin
        // loads during a merge or past capacity are dropped
        if (merge_cnt == 0 && batch_cnt < RUNS) begin
          batch_cnt++;
          heap_key[batch_cnt] = k;
          heap_run[batch_cnt] = RUN_W'(batch_cnt - 1);
        end
      end
      MODE_START: begin
        merge_cnt = batch_cnt;
        batch_cnt = 0;
        for (i = merge_cnt / 2; i > 0; i--) sift_heap(i);
        queue_top();
      end
      default: begin
        if (merge_cnt != 0) begin
          if (m == MODE_NEXT) begin
            heap_key[1] = k;
          end else begin
            heap_key[1] = heap_key[merge_cnt];
            heap_run[1] = heap_run[merge_cnt];
            merge_cnt--;
          end
          sift_heap(1);
        end
        queue_top();
      end
    endcase
  endfunction

  task automatic send_request(mode_t m, logic [KEY_W-1:0] k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{mode: m, key: k};
    do @(posedge clk); while (!in_ready);
    merge_request(m, k);
    n_requests++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_results();
    while (merge_results.size() != 0) @(negedge clk);
  endtask

  // ties, extremes and full-range values
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 7));
      1:       return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [KEY_W-1:0] heads [17] = '{
      32'd5, 32'd5, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd5, 32'd1, 32'd1,
      32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'd9, 32'd0, 32'hFFFF_FFFF,
      32'd4, 32'd6, 32'd1
    };
    // requests with nothing loaded all give done
    send_request(MODE_NEXT, 32'hFFFF_FFFF);
    send_request(MODE_LAST, 32'h0);
    send_request(MODE_START, 32'h0);
    // full batch plus one load past capacity
    foreach (heads[i]) send_request(MODE_LOAD, heads[i]);
    send_request(MODE_START, 32'h0);
    send_request(MODE_NEXT, 32'hFFFF_FFFF);
    send_request(MODE_LAST, 32'h0);
    send_request(MODE_LOAD, 32'h0);
    // start with an empty batch abandons the merge
    send_request(MODE_START, 32'hFFFF_FFFF);
    n_merges++;
  endtask

  task automatic test_random_merges(int target);
    int               n_loads;
    int               sel;
    logic [KEY_W-1:0] k;
    while (n_requests < target) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) n_loads = 0;
      else if (sel <= 2) n_loads = $urandom_range(RUNS + 1, RUNS + 4);
      else if (sel <= 5) n_loads = RUNS;
      else n_loads = $urandom_range(1, RUNS - 1);
      repeat (n_loads) send_request(MODE_LOAD, pick_key());
      send_request(MODE_START, $urandom);
      n_merges++;
      while (merge_cnt != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          // next key of a sorted run: not below the one just emitted
          k = heap_key[1];
          k = (k > 32'hFFFF_FFFF - 1000) ? 32'hFFFF_FFFF : k + $urandom_range(0, 1000);
          send_request(MODE_NEXT, k);
        end else if (sel < 92) begin
          send_request(MODE_LAST, $urandom);
        end else if (sel < 95) begin
          send_request(MODE_LOAD, pick_key());
        end else if (sel < 97) begin
          send_request(MODE_START, $urandom);
        end else begin
          send_request(MODE_NEXT, pick_key());
        end
      end
      if ($urandom_range(0, 1) == 1)
        send_request($urandom_range(0, 1) ? MODE_NEXT : MODE_LAST, $urandom);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_paused_sender();
    int i;
    // hold each request until the previous result has left the block
    repeat (2) begin
      for (i = 0; i < 9; i++) send_request(MODE_LOAD, pick_key());
      send_request(MODE_START, 32'h0);
      n_merges++;
      while (merge_cnt != 0) begin
        wait_results();
        if ($urandom_range(0, 1) == 1) send_request(MODE_NEXT, heap_key[1]);
        else send_request(MODE_LAST, 32'h0);
      end
      wait_results();
      send_request(MODE_LAST, 32'h0);
    end
  endtask

  // result side: random stall per result, with ready high when no_gaps is set
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall == 0) begin
        out_ready = 1'b1;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
      end else begin
        out_ready = 1'b0;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
        repeat (stall - 1) @(negedge clk);
        out_ready = 1'b1;
        @(posedge clk);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (merge_results.size() == 0) begin
        $error("unexpected result: key %h run %0d done %0b",
               out_data.out_key, out_data.out_run, out_data.done_res);
        err_cnt++;
      end else begin
        e = merge_results.pop_front();
        if (e.done_res) n_done++;
        if (out_data.out_key !== e.out_key) begin
          $error("out_key: expected %h, got %h", e.out_key, out_data.out_key);
          err_cnt++;
        end
        if (out_data.out_run !== e.out_run) begin
          $error("out_run: expected %0d, got %0d", e.out_run, out_data.out_run);
          err_cnt++;
        end
        if (out_data.done_res !== e.done_res) begin
          $error("done_res: expected %0b, got %0b", e.done_res, out_data.done_res);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("k_way_heap_merger_top_tb: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '{mode: MODE_LOAD, key: '0};
    merge_cnt = 0;
    batch_cnt = 0;
    err_cnt = 0;
    n_requests = 0;
    n_results = 0;
    n_done = 0;
    n_merges = 0;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_merges(RANDOM_ITEMS);
    test_paused_sender();

    wait_results();
    repeat (200) @(negedge clk);
    if (merge_results.size() != 0) begin
      $error("%0d results never arrived", merge_results.size());
      err_cnt++;
    end
    $display("%0d requests over %0d merges, %0d results checked (%0d done)",
             n_requests, n_merges, n_results, n_done);
    $display("covered empty requests, full and overflowing batches, ties and aborted merges");
    if (err_cnt == 0) begin
      $display("k_way_heap_merger_top_tb: clean");
    end else begin
      $display("k_way_heap_merger_top_tb: errors");
    end
    $finish;
  end

endmodule

FILE: k_way_heap_merger_top.f
src/kwhm_pkg.sv
src/kwhm_dpath.sv
src/kwhm_ctrl.sv
src/k_way_heap_merger_top.sv
tb/sv/k_way_heap_merger_top_tb.sv
